[rtl/core/assert_macros.svh]
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during rst
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_SAME(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/core/knos_pkg.sv]
// shared types and constants for the k nearest point selector
`timescale 1ns / 1ps

package knos_pkg;

  localparam int MAX_K_DEFAULT = 16;
  localparam int COORD_W       = 16;
  localparam int DIST_W        = 32;
  localparam int KCFG_W        = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_INSERT,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic square;
    logic sum;
    logic insert;
    logic emit_shift;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
    logic final_entry;
  } sts_t;

endpackage

[rtl/core/knos_ctrl.sv]
// sequencing state machine for the k nearest point selector
`timescale 1ns / 1ps
`include "assert_macros.svh"

module knos_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  knos_pkg::sts_t  sts,
  output knos_pkg::cmd_t  cmd
);

  knos_pkg::state_t state;
  knos_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= knos_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      knos_pkg::ST_IDLE: begin
        if (in_valid) state_next = knos_pkg::ST_SQUARE;
      end
      knos_pkg::ST_SQUARE: state_next = knos_pkg::ST_SUM;
      knos_pkg::ST_SUM:    state_next = knos_pkg::ST_INSERT;
      knos_pkg::ST_INSERT: begin
        state_next = sts.last ? knos_pkg::ST_EMIT : knos_pkg::ST_IDLE;
      end
      knos_pkg::ST_EMIT: begin
        if (out_ready && sts.final_entry) state_next = knos_pkg::ST_IDLE;
      end
      default: state_next = knos_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    case (state)
      knos_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      knos_pkg::ST_SQUARE: cmd.square = 1'b1;
      knos_pkg::ST_SUM:    cmd.sum    = 1'b1;
      knos_pkg::ST_INSERT: cmd.insert = 1'b1;
      knos_pkg::ST_EMIT: begin
        out_valid      = 1'b1;
        cmd.emit_shift = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  `ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state == knos_pkg::ST_SQUARE, "accepted point did not start squaring")
  `ASSERT_NEXT(a_mid_run_idle, (state == knos_pkg::ST_INSERT) && !sts.last, state == knos_pkg::ST_IDLE, "non-final point did not return to idle")
  `ASSERT_NEXT(a_final_out_idle, out_valid && out_ready && sts.final_entry, state == knos_pkg::ST_IDLE, "final result did not end emission")

endmodule

[rtl/core/knos_datapath.sv]
// distance pipeline and compare-and-shift list of kept points
`timescale 1ns / 1ps
`include "assert_macros.svh"

module knos_datapath #(
  parameter int MAX_K = knos_pkg::MAX_K_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [knos_pkg::KCFG_W-1:0]         k_count,
  input  logic signed [knos_pkg::COORD_W-1:0] point_x,
  input  logic signed [knos_pkg::COORD_W-1:0] point_y,
  input  logic                                last_point,
  input  knos_pkg::cmd_t                      cmd,
  output knos_pkg::sts_t                      sts,
  output logic signed [knos_pkg::COORD_W-1:0] near_x,
  output logic signed [knos_pkg::COORD_W-1:0] near_y,
  output logic [knos_pkg::DIST_W-1:0]         dist_sq,
  output logic                                last_result
);

  localparam int CW = $clog2(MAX_K + 1);
  localparam int IW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  logic [knos_pkg::KCFG_W-1:0]         k_reg;
  logic signed [knos_pkg::COORD_W-1:0] px;
  logic signed [knos_pkg::COORD_W-1:0] py;
  logic                                plast;
  logic [knos_pkg::COORD_W-1:0]        ax;
  logic [knos_pkg::COORD_W-1:0]        ay;
  logic [knos_pkg::DIST_W-1:0]         sq_x;
  logic [knos_pkg::DIST_W-1:0]         sq_y;
  logic [knos_pkg::DIST_W-1:0]         new_dist;

  logic signed [knos_pkg::COORD_W-1:0] cell_x    [MAX_K];
  logic signed [knos_pkg::COORD_W-1:0] cell_y    [MAX_K];
  logic [knos_pkg::DIST_W-1:0]         cell_dist [MAX_K];
  logic [CW-1:0]                       kept_count;
  logic [CW-1:0]                       kept_count_next;

  logic [CW-1:0]    lim;
  logic [CW-1:0]    cnt_trunc;
  logic [IW-1:0]    lim_idx;
  logic [MAX_K-1:0] le;
  logic             ins_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_reg <= knos_pkg::KCFG_W'(1);
    end else if (cfg_wen) begin
      k_reg <= k_count;
    end
  end

  // effective k: zero acts as one, large values saturate
  always_comb begin
    if (k_reg == '0) begin
      lim = CW'(1);
    end else if (int'(k_reg) > MAX_K) begin
      lim = CW'(MAX_K);
    end else begin
      lim = CW'(k_reg);
    end
    cnt_trunc = (kept_count > lim) ? lim : kept_count;
    lim_idx   = IW'(lim - CW'(1));
  end

  assign ax = px[knos_pkg::COORD_W-1] ? knos_pkg::COORD_W'(-px) : knos_pkg::COORD_W'(px);
  assign ay = py[knos_pkg::COORD_W-1] ? knos_pkg::COORD_W'(-py) : knos_pkg::COORD_W'(py);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px    <= point_x;
      py    <= point_y;
      plast <= last_point;
    end
    if (cmd.square) begin
      sq_x <= knos_pkg::DIST_W'(ax) * knos_pkg::DIST_W'(ax);
      sq_y <= knos_pkg::DIST_W'(ay) * knos_pkg::DIST_W'(ay);
    end
    if (cmd.sum) begin
      new_dist <= sq_x + sq_y;
    end
  end

  // dropped only when the list is full and no kept entry is farther
  assign ins_ok = !((cnt_trunc == lim) && le[lim_idx]);

  always_comb begin
    kept_count_next = kept_count;
    if (cmd.insert) begin
      if (ins_ok) begin
        kept_count_next = (cnt_trunc < lim) ? cnt_trunc + CW'(1) : lim;
      end else begin
        kept_count_next = cnt_trunc;
      end
    end else if (cmd.emit_shift) begin
      kept_count_next = kept_count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
    end else begin
      kept_count <= kept_count_next;
    end
  end

  for (genvar g = 0; g < MAX_K; g++) begin : g_cell
    logic prev_le;

    // sorted list, so le is a prefix of ones
    assign le[g] = (CW'(g) < cnt_trunc) && (cell_dist[g] <= new_dist);

    if (g == 0) begin : g_head
      assign prev_le = 1'b1;
    end else begin : g_body
      assign prev_le = le[g-1];
    end

    always_ff @(posedge clk) begin
      if (cmd.insert && ins_ok && !le[g]) begin
        if (prev_le) begin
          cell_x[g]    <= px;
          cell_y[g]    <= py;
          cell_dist[g] <= new_dist;
        end else begin
          cell_x[g]    <= cell_x[(g > 0) ? g - 1 : 0];
          cell_y[g]    <= cell_y[(g > 0) ? g - 1 : 0];
          cell_dist[g] <= cell_dist[(g > 0) ? g - 1 : 0];
        end
      end else if (cmd.emit_shift && (g < MAX_K - 1)) begin
        cell_x[g]    <= cell_x[(g < MAX_K - 1) ? g + 1 : g];
        cell_y[g]    <= cell_y[(g < MAX_K - 1) ? g + 1 : g];
        cell_dist[g] <= cell_dist[(g < MAX_K - 1) ? g + 1 : g];
      end
    end
  end

  assign sts.last        = plast;
  assign sts.final_entry = (kept_count == CW'(1));

  assign near_x      = cell_x[0];
  assign near_y      = cell_y[0];
  assign dist_sq     = cell_dist[0];
  assign last_result = (kept_count == CW'(1));

  `ASSERT_SAME(a_count_bound, 1'b1, kept_count <= CW'(MAX_K), "kept count above list depth")
  `ASSERT_SAME(a_emit_nonempty, cmd.emit_shift, kept_count != '0, "emission from an empty list")
  `ASSERT_NEXT(a_insert_fills, cmd.insert && ins_ok, (kept_count != '0) && (kept_count <= lim), "insert left count out of range")

endmodule

[rtl/core/k_nearest_to_origin_select_top.sv]
// top level of the k nearest to origin point selector
`timescale 1ns / 1ps

// Streams 2-D points and keeps the k_count points with the smallest squared
// distance x*x+y*y in ascending order, ties in arrival order; the point
// flagged last_point closes the run and the kept points come out nearest
// first, last_result on the final one (fewer than k if fewer arrived). Each
// point goes through capture, square (two 16x16 multipliers), sum, and one
// parallel compare-and-shift insert across the MAX_K list cells. Results
// leave at one per accepted cycle from the head cell; no point is taken while
// results are pending. k_count 0 acts as 1, values above MAX_K saturate, and
// a lower k cuts the list at the next insert. No clearing pass after reset.
module k_nearest_to_origin_select_top #(
  parameter int MAX_K = knos_pkg::MAX_K_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [knos_pkg::KCFG_W-1:0]         k_count,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [knos_pkg::COORD_W-1:0] point_x,
  input  logic signed [knos_pkg::COORD_W-1:0] point_y,
  input  logic                                last_point,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [knos_pkg::COORD_W-1:0] near_x,
  output logic signed [knos_pkg::COORD_W-1:0] near_y,
  output logic [knos_pkg::DIST_W-1:0]         dist_sq,
  output logic                                last_result
);

  knos_pkg::cmd_t cmd;
  knos_pkg::sts_t sts;

  knos_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  knos_datapath #(
    .MAX_K (MAX_K)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .k_count     (k_count),
    .point_x     (point_x),
    .point_y     (point_y),
    .last_point  (last_point),
    .cmd         (cmd),
    .sts         (sts),
    .near_x      (near_x),
    .near_y      (near_y),
    .dist_sq     (dist_sq),
    .last_result (last_result)
  );

endmodule
